### rtl/spring_damper_force_top_defines.svh
// Assertion macros for the spring-damper force block.
// Included by spring_damper_force_top.sv; no other dependencies.
`ifndef SPRING_DAMPER_FORCE_TOP_DEFINES_SVH
`define SPRING_DAMPER_FORCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spring_damper_force assertion failed");
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spring_damper_force assertion failed");
`else
`define SDF_ASSERT(lbl, prop)
`define SDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/sdf_pkg.sv
// Package for the spring-damper force block: widths, stage positions and
// the per-stage record type. No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_STIFFNESS   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_REST_LENGTH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DAMPING     = IDX_W'(2);

  localparam int DM_W  = DATA_W + 1;            // magnitude of a difference
  localparam int RT_W  = DM_W;                  // square root width
  localparam int SQ_W  = 2 * RT_W;              // sum of squares
  localparam int REM_W = RT_W + 3;              // root remainder
  localparam int AS_W  = RT_W + 1;              // |r - rest_length|
  localparam int GM_W  = DM_W + CFG_W - FRAC_BITS;
  localparam int M_W   = CFG_W + AS_W - FRAC_BITS;
  localparam int DR_W  = RT_W + 1;              // divider remainder
  localparam int U_W   = FRAC_BITS + 1;         // unit component
  localparam int HM_W  = M_W + U_W - FRAC_BITS;
  localparam int TW    = HM_W + 2;              // sum before saturation

  localparam logic [U_W-1:0]    UNIT_ONE = U_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

  localparam int ST_IN    = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQRT0 = 3;
  localparam int ST_LEN   = ST_SQRT0 + RT_W;
  localparam int ST_MUL   = ST_LEN + 1;
  localparam int ST_DIV0  = ST_MUL + 1;
  localparam int ST_HM    = ST_DIV0 + FRAC_BITS;
  localparam int ST_OUT   = ST_HM + 1;
  localparam int NST      = ST_OUT + 1;

  typedef struct packed {
    logic [2:0][DM_W-1:0]  dmag;
    logic [2:0]            dneg;
    logic [2:0][DM_W-1:0]  dvmag;
    logic [2:0]            dvneg;
    logic [2:0][GM_W-1:0]  gm;
    logic [2:0][SQ_W-1:0]  sq;
    logic [SQ_W-1:0]       sum;
    logic [REM_W-1:0]      rem;
    logic [RT_W-1:0]       root;
    logic [AS_W-1:0]       abs_s;
    logic                  s_neg;
    logic                  nz;
    logic [M_W-1:0]        m;
    logic [2:0][DR_W-1:0]  drem;
    logic [2:0][U_W-1:0]   u;
    logic [2:0][HM_W-1:0]  hm;
    logic [2:0][DATA_W-1:0] frc;
    logic                  coin;
  } sdf_stage_t;

endpackage

### rtl/spring_damper_force_top.sv
// Damped spring force on the first end; one spring per cycle unless stalled.
// Depends on sdf_pkg and spring_damper_force_top_defines.svh.
`timescale 1ns / 1ps
`include "spring_damper_force_top_defines.svh"

// A new spring word may enter on every clock while in_stall_o is low; data
// is Q16.16. The separation length comes from a square root that resolves
// one root bit per stage over 33 stages, and the unit vector from a restoring
// divider that resolves one quotient bit per stage over FRAC_BITS + 1 stages.
// A two-entry output (last stage plus a skid register) lets the pipe keep
// moving after the consumer stalls until the stalled word is in the skid
// register; input stall is taken straight from the skid register.
// Configuration registers must only be written while the pipe is empty.
module spring_damper_force_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sdf_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [sdf_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_pos_x_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_pos_y_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_pos_z_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_pos_x_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_pos_y_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_pos_z_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_vel_x_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_vel_y_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   first_vel_z_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_vel_x_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_vel_y_i,
  input  logic signed [sdf_pkg::DATA_W-1:0]   second_vel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sdf_pkg::DATA_W-1:0]   force_x_o,
  output logic signed [sdf_pkg::DATA_W-1:0]   force_y_o,
  output logic signed [sdf_pkg::DATA_W-1:0]   force_z_o,
  output logic                                coincident_o
);
  import sdf_pkg::*;

  logic [CFG_W-1:0] stiffness_q, rest_length_q, damping_q;

  logic [NST-1:0] valid_q;
  sdf_stage_t     pipe_q [NST];
  sdf_stage_t     pipe_d [NST];
  logic           en;
  logic           in_acc, out_acc;

  logic           skid_v_q, skid_v_d;
  logic [2:0][DATA_W-1:0] skid_frc_q;
  logic           skid_coin_q;

  logic [2:0][DATA_W-1:0] pa, pb, va, vb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= '0;
      rest_length_q <= '0;
      damping_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STIFFNESS:   stiffness_q   <= cfg_data_i[CFG_W-1:0];
        REG_REST_LENGTH: rest_length_q <= cfg_data_i[CFG_W-1:0];
        REG_DAMPING:     damping_q     <= cfg_data_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipe only freezes once the skid register holds a word.
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  assign pa = {first_pos_z_i, first_pos_y_i, first_pos_x_i};
  assign pb = {second_pos_z_i, second_pos_y_i, second_pos_x_i};
  assign va = {first_vel_z_i, first_vel_y_i, first_vel_x_i};
  assign vb = {second_vel_z_i, second_vel_y_i, second_vel_x_i};

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == ST_IN) begin : g_in
      always_comb begin
        logic [DM_W-1:0] dp, dv;
        pipe_d[k] = '0;
        for (int i = 0; i < 3; i++) begin
          dp = {pa[i][DATA_W-1], pa[i]} - {pb[i][DATA_W-1], pb[i]};
          dv = {va[i][DATA_W-1], va[i]} - {vb[i][DATA_W-1], vb[i]};
          pipe_d[k].dneg[i]  = dp[DM_W-1];
          pipe_d[k].dmag[i]  = dp[DM_W-1] ? (~dp + DM_W'(1)) : dp;
          pipe_d[k].dvneg[i] = dv[DM_W-1];
          pipe_d[k].dvmag[i] = dv[DM_W-1] ? (~dv + DM_W'(1)) : dv;
        end
      end
    end else if (k == ST_SQ) begin : g_sq
      always_comb begin
        logic [DM_W+CFG_W-1:0] gp;
        pipe_d[k] = pipe_q[k-1];
        for (int i = 0; i < 3; i++) begin
          pipe_d[k].sq[i] = pipe_q[k-1].dmag[i] * pipe_q[k-1].dmag[i];
          gp = pipe_q[k-1].dvmag[i] * damping_q;
          pipe_d[k].gm[i] = gp[DM_W+CFG_W-1:FRAC_BITS];
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].sum  = pipe_q[k-1].sq[0] + pipe_q[k-1].sq[1] + pipe_q[k-1].sq[2];
        pipe_d[k].rem  = '0;
        pipe_d[k].root = '0;
      end
    end else if (k < ST_LEN) begin : g_sqrt
      // One root bit per stage, most significant bit pair first. The trial
      // subtrahend is four times the partial root plus one.
      localparam int J = RT_W - 1 - (k - ST_SQRT0);
      always_comb begin
        logic [REM_W-1:0] sh, trial;
        pipe_d[k] = pipe_q[k-1];
        sh    = {pipe_q[k-1].rem[REM_W-3:0], pipe_q[k-1].sum[2*J+1:2*J]};
        trial = {1'b0, pipe_q[k-1].root, 2'b01};
        if (sh >= trial) begin
          pipe_d[k].rem  = sh - trial;
          pipe_d[k].root = {pipe_q[k-1].root[RT_W-2:0], 1'b1};
        end else begin
          pipe_d[k].rem  = sh;
          pipe_d[k].root = {pipe_q[k-1].root[RT_W-2:0], 1'b0};
        end
      end
    end else if (k == ST_LEN) begin : g_len
      always_comb begin
        logic [AS_W-1:0] r, rl;
        pipe_d[k] = pipe_q[k-1];
        r  = {1'b0, pipe_q[k-1].root};
        rl = {{(AS_W-CFG_W){1'b0}}, rest_length_q};
        pipe_d[k].nz = |pipe_q[k-1].root;
        if (r >= rl) begin
          pipe_d[k].abs_s = r - rl;
          pipe_d[k].s_neg = 1'b0;
        end else begin
          pipe_d[k].abs_s = rl - r;
          pipe_d[k].s_neg = 1'b1;
        end
      end
    end else if (k == ST_MUL) begin : g_mul
      // Spring magnitude product, and the top quotient bit of the divider.
      always_comb begin
        logic [CFG_W+AS_W-1:0] mp;
        logic [DR_W-1:0]       num, den;
        pipe_d[k] = pipe_q[k-1];
        mp = stiffness_q * pipe_q[k-1].abs_s;
        pipe_d[k].m = mp[CFG_W+AS_W-1:FRAC_BITS];
        den = {1'b0, pipe_q[k-1].root};
        for (int i = 0; i < 3; i++) begin
          num = {1'b0, pipe_q[k-1].dmag[i]};
          pipe_d[k].u[i] = '0;
          if (num >= den) begin
            pipe_d[k].u[i][FRAC_BITS] = 1'b1;
            pipe_d[k].drem[i] = num - den;
          end else begin
            pipe_d[k].drem[i] = num;
          end
        end
      end
    end else if (k < ST_HM) begin : g_div
      localparam int B = FRAC_BITS - 1 - (k - ST_DIV0);
      always_comb begin
        logic [DR_W-1:0] sh, den;
        pipe_d[k] = pipe_q[k-1];
        den = {1'b0, pipe_q[k-1].root};
        for (int i = 0; i < 3; i++) begin
          sh = {pipe_q[k-1].drem[i][DR_W-2:0], 1'b0};
          if (sh >= den) begin
            pipe_d[k].u[i][B] = 1'b1;
            pipe_d[k].drem[i] = sh - den;
          end else begin
            pipe_d[k].drem[i] = sh;
          end
        end
      end
    end else if (k == ST_HM) begin : g_hm
      always_comb begin
        logic [U_W-1:0]      uc;
        logic [M_W+U_W-1:0]  hp;
        pipe_d[k] = pipe_q[k-1];
        for (int i = 0; i < 3; i++) begin
          uc = (pipe_q[k-1].u[i] > UNIT_ONE) ? UNIT_ONE : pipe_q[k-1].u[i];
          hp = pipe_q[k-1].m * uc;
          pipe_d[k].hm[i] = pipe_q[k-1].nz ? hp[M_W+U_W-1:FRAC_BITS] : '0;
        end
      end
    end else begin : g_out
      always_comb begin
        logic [TW-1:0] hx, gx, tot;
        pipe_d[k] = pipe_q[k-1];
        for (int i = 0; i < 3; i++) begin
          hx = {2'b00, pipe_q[k-1].hm[i]};
          gx = {{(TW-GM_W){1'b0}}, pipe_q[k-1].gm[i]};
          // The Hooke term points along -s * d, the damping term along -dv.
          if (pipe_q[k-1].dneg[i] == pipe_q[k-1].s_neg) hx = ~hx + TW'(1);
          if (!pipe_q[k-1].dvneg[i]) gx = ~gx + TW'(1);
          tot = hx + gx;
          if ((&tot[TW-1:DATA_W-1]) || !(|tot[TW-1:DATA_W-1])) begin
            pipe_d[k].frc[i] = tot[DATA_W-1:0];
          end else begin
            pipe_d[k].frc[i] = tot[TW-1] ? SAT_NEG : SAT_POS;
          end
        end
        pipe_d[k].coin = !pipe_q[k-1].nz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) pipe_q[k] <= pipe_d[k];
    end
  end

  // The skid register catches the last-stage word when the consumer stalls.
  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (!out_stall_i) skid_v_d = 1'b0;
    end else if (valid_q[NST-1] && out_stall_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_frc_q  <= pipe_q[NST-1].frc;
      skid_coin_q <= pipe_q[NST-1].coin;
    end
  end

  assign out_valid_o  = skid_v_q || valid_q[NST-1];
  assign force_x_o    = skid_v_q ? skid_frc_q[0] : pipe_q[NST-1].frc[0];
  assign force_y_o    = skid_v_q ? skid_frc_q[1] : pipe_q[NST-1].frc[1];
  assign force_z_o    = skid_v_q ? skid_frc_q[2] : pipe_q[NST-1].frc[2];
  assign coincident_o = skid_v_q ? skid_coin_q : pipe_q[NST-1].coin;

  `SDF_ASSERT(a_stall_only_when_full, in_stall_o |-> out_valid_o)
  `SDF_ASSERT_NEXT(a_word_count, 1'b1, ($countones(valid_q) + int'(skid_v_q)) == ($past($countones(valid_q)) + int'($past(skid_v_q)) + int'($past(in_acc)) - int'($past(out_acc))))
  `SDF_ASSERT_NEXT(a_skid_drains, skid_v_q && !out_stall_i, !skid_v_q)

endmodule

### verif/tb_spring_damper_force_top.sv
// Self-checking testbench for spring_damper_force_top: random and directed spring words
// are checked against a bit-accurate force predictor held in a scoreboard class.
// Depends on sdf_pkg and the RTL of spring_damper_force_top.
`timescale 1ns / 1ps

module tb_spring_damper_force_top;
  import sdf_pkg::*;

  typedef logic [11:0][DATA_W-1:0] spring_t;
  typedef struct {
    logic [DATA_W-1:0] fx, fy, fz;
    logic              coin;
  } force_t;

  class force_scoreboard;
    logic [CFG_W-1:0] stiff, rest, damp;
    force_t           pending[$];
    int               errors;

    function new();
      stiff = '0; rest = '0; damp = '0; errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_STIFFNESS:   stiff = val[CFG_W-1:0];
        REG_REST_LENGTH: rest  = val[CFG_W-1:0];
        REG_DAMPING:     damp  = val[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [127:0] floor_sqrt(logic [127:0] v);
      logic [127:0] r, t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function logic [DATA_W-1:0] clip(logic signed [127:0] v);
      if (v > 128'sd2147483647) return SAT_POS;
      if (v < -128'sd2147483648) return SAT_NEG;
      return v[DATA_W-1:0];
    endfunction

    // Predicts the force on the first end for one accepted spring word.
    function void note_spring(spring_t s);
      logic signed [127:0] d[3], dv[3], h, g;
      logic [127:0] dmag[3], dvmag, sum, r, abs_s, m, u, hm, gm;
      logic [DATA_W-1:0] res[3];
      logic s_neg;
      force_t e;
      sum = '0; s_neg = 1'b0; m = '0;
      for (int i = 0; i < 3; i++) begin
        d[i]    = $signed(s[i]) - $signed(s[3+i]);
        dv[i]   = $signed(s[6+i]) - $signed(s[9+i]);
        dmag[i] = d[i] < 0 ? -d[i] : d[i];
        sum     = sum + dmag[i] * dmag[i];
      end
      r = floor_sqrt(sum);
      if (r != 0) begin
        if (r >= rest) abs_s = r - rest;
        else begin
          abs_s = rest - r;
          s_neg = 1'b1;
        end
        m = (stiff * abs_s) >> FRAC_BITS;
      end
      for (int i = 0; i < 3; i++) begin
        h = '0;
        if (r != 0) begin
          u = (dmag[i] << FRAC_BITS) / r;
          // r is rounded down, yet each |d| is at most r, so a unit component never exceeds one.
          if (u > (128'd1 << FRAC_BITS)) u = 128'd1 << FRAC_BITS;
          hm = (m * u) >> FRAC_BITS;
          h  = ((d[i] < 0) != s_neg) ? $signed(hm) : -$signed(hm);
        end
        dvmag = dv[i] < 0 ? -dv[i] : dv[i];
        gm    = (dvmag * damp) >> FRAC_BITS;
        g     = dv[i] < 0 ? $signed(gm) : -$signed(gm);
        res[i] = clip(h + g);
      end
      e.fx = res[0]; e.fy = res[1]; e.fz = res[2];
      e.coin = (r == 0);
      pending.push_back(e);
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_force(force_t got);
      force_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got.fx, '0);
        return;
      end
      want = pending.pop_front();
      if (got.fx !== want.fx) report_mismatch("force_x", got.fx, want.fx);
      if (got.fy !== want.fy) report_mismatch("force_y", got.fy, want.fy);
      if (got.fz !== want.fz) report_mismatch("force_z", got.fz, want.fz);
      if (got.coin !== want.coin) report_mismatch("coincident", got.coin, want.coin);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  spring_t spring = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [DATA_W-1:0] fx, fy, fz;
  logic coin;
  bit   no_gaps = 1'b0;
  int   cycles = 0;
  force_scoreboard sb = new();

  localparam int CYCLE_LIMIT = 400000;

  always #10 clk = ~clk;

  spring_damper_force_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_pos_x_i(spring[0]), .first_pos_y_i(spring[1]), .first_pos_z_i(spring[2]),
    .second_pos_x_i(spring[3]), .second_pos_y_i(spring[4]), .second_pos_z_i(spring[5]),
    .first_vel_x_i(spring[6]), .first_vel_y_i(spring[7]), .first_vel_z_i(spring[8]),
    .second_vel_x_i(spring[9]), .second_vel_y_i(spring[10]), .second_vel_z_i(spring[11]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .force_x_o(fx), .force_y_o(fy), .force_z_o(fz), .coincident_o(coin)
  );

  always @(posedge clk) begin
    force_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.fx = fx; got.fy = fy; got.fz = fz; got.coin = coin;
      sb.check_force(got);
    end
  end

  // Result side: stall for a random number of cycles before each word, or not at all while no_gaps is set.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall = 1'b1;
      repeat (no_gaps ? 0 : $urandom_range(0, 14)) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_spring(spring_t s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    spring   = s;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_spring(s);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NST + 10) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1 << 20);
      1: return -$urandom_range(0, 1 << 20);
      2: case ($urandom_range(0, 3))
           0: return SAT_NEG;
           1: return SAT_POS;
           2: return '0;
           default: return '1;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic spring_t pick_spring();
    spring_t s;
    int mode;
    for (int i = 0; i < 12; i++) s[i] = pick_word();
    mode = $urandom_range(0, 19);
    // In half of the cases the ends are close together or coincide, so the Hooke term stays in range.
    for (int i = 0; i < 3; i++) begin
      if (mode == 0) s[3+i] = s[i];
      else if (mode < 10) s[3+i] = s[i] + $signed($urandom_range(0, 1 << 19) - (1 << 18));
    end
    return s;
  endfunction

  initial begin
    spring_t s;
    logic [DATA_W-1:0] k[5], l[5], c[5];
    k = '{32'h0, 32'h7fff_ffff, 32'h0001_0000, 32'h0, 32'h0000_0100};
    l = '{32'h0, 32'h7fff_ffff, 32'h0002_0000, 32'h0, 32'h0000_8000};
    c = '{32'h0, 32'h7fff_ffff, 32'h0000_8000, 32'h0, 32'h0003_0000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        if (p == 3) begin
          k[p] = $urandom; l[p] = $urandom; c[p] = $urandom;
        end
        write_reg(REG_STIFFNESS, k[p]);
        write_reg(REG_REST_LENGTH, l[p]);
        write_reg(REG_DAMPING, c[p]);
        // An index past the last register must change nothing.
        write_reg(2'd3, $urandom);
      end
      if (p == 1) begin
        s = '0; send_spring(s);
        for (int i = 0; i < 12; i++) s[i] = SAT_POS;
        send_spring(s);
        for (int i = 0; i < 12; i++) s[i] = SAT_NEG;
        send_spring(s);
        for (int i = 0; i < 12; i++) s[i] = i[0] ? SAT_POS : SAT_NEG;
        send_spring(s);
        for (int i = 0; i < 12; i++) s[i] = i[0] ? SAT_NEG : SAT_POS;
        send_spring(s);
        s = '0; s[6] = SAT_POS; s[9] = SAT_NEG; s[7] = SAT_NEG; s[10] = SAT_POS;
        send_spring(s);
        s = '0; s[0] = 32'h0001_0000; send_spring(s);
        s = '0; s[0] = 32'h0001_0000; s[1] = 32'h0001_0000; s[2] = 32'h0001_0000;
        send_spring(s);
        s = '0; s[0] = 32'h0000_0001; s[1] = 32'h0000_0001; send_spring(s);
        s = '0; s[0] = SAT_POS; s[3] = SAT_NEG; send_spring(s);
        s = '0; s[1] = 32'h0010_0000; s[4] = 32'h0010_0000; s[8] = 32'hffff_0000;
        send_spring(s);
      end
      for (int n = 0; n < 280; n++) begin
        if (n % 70 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_spring(pick_spring());
      end
      no_gaps = 1'b0;
      drain();
    end
    // High bit of a register write is dropped.
    write_reg(REG_STIFFNESS, 32'hffff_ffff);
    write_reg(REG_REST_LENGTH, 32'h8000_0000);
    write_reg(REG_DAMPING, 32'h8000_0001);
    for (int n = 0; n < 20; n++) send_spring(pick_spring());
    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sdf_pkg.sv
rtl/spring_damper_force_top.sv
verif/tb_spring_damper_force_top.sv
